/* sv/union_move_find_sets_top_defines.svh */
// Assertion helpers for the union/move/find-sets engine.
`ifndef UNION_MOVE_FIND_SETS_TOP_DEFINES_SVH
`define UNION_MOVE_FIND_SETS_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UMFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UMFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/umfs_pkg.sv */
package umfs_pkg;

    localparam int ElemW  = 11;
    localparam int CountW = 11;
    localparam int SumW   = 20;
    localparam int StCntW = 32;

    // input action codes
    localparam logic [1:0] ACT_UNION = 2'd0;
    localparam logic [1:0] ACT_MOVE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // classified command codes
    localparam logic [2:0] OP_UNION = 3'd0;
    localparam logic [2:0] OP_MOVE  = 3'd1;
    localparam logic [2:0] OP_QUERY = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_BAD   = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [ElemW-1:0] p;
        logic [ElemW-1:0] q;
    } umfs_cmd_t;

endpackage

/* sv/umfs_ram.sv */
module umfs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/umfs_front.sv */
module umfs_front #(
    parameter int AddrW = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [AddrW-1:0]             active_n,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [umfs_pkg::ElemW-1:0]   s_first_element,
    input  logic [umfs_pkg::ElemW-1:0]   s_second_element,
    output logic                         q_valid,
    output umfs_pkg::umfs_cmd_t          q_cmd,
    input  logic                         q_pop
);

    localparam int NW = (AddrW > umfs_pkg::ElemW) ? AddrW : umfs_pkg::ElemW;

    umfs_pkg::umfs_cmd_t fifo_reg [2];
    logic                wptr_reg, wptr_next;
    logic                rptr_reg, rptr_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                push;
    logic                p_ok, q_ok;
    logic [NW-1:0]       n_ext, p_ext, q_ext;
    umfs_pkg::umfs_cmd_t cmd;

    assign n_ext = NW'(active_n);
    assign p_ext = NW'(s_first_element);
    assign q_ext = NW'(s_second_element);
    assign p_ok  = (p_ext != '0) && (p_ext <= n_ext);
    assign q_ok  = (q_ext != '0) && (q_ext <= n_ext);

    always_comb begin
        cmd.p  = s_first_element;
        cmd.q  = s_second_element;
        cmd.op = umfs_pkg::OP_BAD;
        push   = 1'b1;
        unique case (s_action)
            umfs_pkg::ACT_CLEAR: begin
                cmd.op = umfs_pkg::OP_CLEAR;
                // nothing to clear with no elements in use
                push   = (active_n != '0);
            end
            umfs_pkg::ACT_QUERY: begin
                if (p_ok) cmd.op = umfs_pkg::OP_QUERY;
            end
            umfs_pkg::ACT_MOVE: begin
                if (p_ok && q_ok) cmd.op = umfs_pkg::OP_MOVE;
            end
            default: begin
                if (p_ok && q_ok) cmd.op = umfs_pkg::OP_UNION;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (s_valid && s_ready && push) begin
            wptr_next = ~wptr_reg;
            cnt_next  = cnt_next + 2'd1;
        end
        if (q_pop && q_valid) begin
            rptr_next = ~rptr_reg;
            cnt_next  = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && push) begin
            fifo_reg[wptr_reg] <= cmd;
        end
    end

endmodule

/* sv/umfs_back.sv */
module umfs_back #(
    parameter int MaxElements = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [$clog2(MaxElements+1)-1:0] active_n,
    input  logic                          q_valid,
    input  umfs_pkg::umfs_cmd_t           q_cmd,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [umfs_pkg::CountW-1:0]   m_set_count,
    output logic [umfs_pkg::SumW-1:0]     m_set_sum,
    output logic                          m_status,
    output logic                          init_busy
);

    localparam int AW = $clog2(MaxElements + 1);
    localparam int IW = AW + 1;
    localparam int CW = umfs_pkg::StCntW;
    localparam int SW = umfs_pkg::SumW;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_LA   = 4'd2;
    localparam logic [3:0] S_LB   = 4'd3;
    localparam logic [3:0] S_QW   = 4'd4;
    localparam logic [3:0] S_CA   = 4'd5;
    localparam logic [3:0] S_CB   = 4'd6;
    localparam logic [3:0] S_MV2  = 4'd7;
    localparam logic [3:0] S_SCAN = 4'd8;
    localparam logic [3:0] S_CLR  = 4'd9;
    localparam logic [3:0] S_RESP = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [2:0]    op_reg, op_next;
    logic [umfs_pkg::ElemW-1:0] p_reg, p_next, q_reg, q_next;
    logic [AW-1:0] a_reg, a_next, b_reg, b_next;
    logic [AW-1:0] keep_reg, keep_next, drop_reg, drop_next;
    logic [CW-1:0] ca_reg, ca_next;
    logic [SW-1:0] sa_reg, sa_next;
    logic          bad_reg, bad_next;
    logic          mv_reg, mv_next;
    logic [umfs_pkg::CountW-1:0] ocnt_reg, ocnt_next;
    logic [SW-1:0] osum_reg, osum_next;
    logic          ost_reg, ost_next;

    logic          lab_we, cs_we;
    logic [AW-1:0] lab_waddr, lab_raddr, cs_waddr, cs_raddr;
    logic [AW-1:0] lab_wdata, lab_rdata;
    logic [CW-1:0] cnt_wdata, cnt_rdata;
    logic [SW-1:0] sum_wdata, sum_rdata;
    logic [IW-1:0] n_ext;
    logic [SW-1:0] p_sum;

    assign n_ext = IW'(active_n);
    assign p_sum = SW'(p_reg);

    umfs_ram #(.Width(AW), .Depth(MaxElements + 1)) u_label_ram (
        .aclk(aclk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
        .raddr(lab_raddr), .rdata(lab_rdata)
    );
    umfs_ram #(.Width(CW), .Depth(MaxElements + 1)) u_count_ram (
        .aclk(aclk), .we(cs_we), .waddr(cs_waddr), .wdata(cnt_wdata),
        .raddr(cs_raddr), .rdata(cnt_rdata)
    );
    umfs_ram #(.Width(SW), .Depth(MaxElements + 1)) u_sum_ram (
        .aclk(aclk), .we(cs_we), .waddr(cs_waddr), .wdata(sum_wdata),
        .raddr(cs_raddr), .rdata(sum_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        op_next        = op_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        keep_next      = keep_reg;
        drop_next      = drop_reg;
        ca_next        = ca_reg;
        sa_next        = sa_reg;
        bad_next       = bad_reg;
        mv_next        = mv_reg;
        ocnt_next      = ocnt_reg;
        osum_next      = osum_reg;
        ost_next       = ost_reg;
        q_pop          = 1'b0;
        lab_we         = 1'b0;
        lab_waddr      = '0;
        lab_wdata      = '0;
        lab_raddr      = '0;
        cs_we          = 1'b0;
        cs_waddr       = '0;
        cs_raddr       = '0;
        cnt_wdata      = '0;
        sum_wdata      = '0;

        if (m_valid && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                lab_we    = 1'b1;
                lab_waddr = idx_reg[AW-1:0];
                lab_wdata = idx_reg[AW-1:0];
                cs_we     = 1'b1;
                cs_waddr  = idx_reg[AW-1:0];
                cnt_wdata = CW'(1);
                sum_wdata = SW'(idx_reg);
                idx_next  = idx_reg + IW'(1);
                if (idx_reg == IW'(MaxElements)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    op_next   = q_cmd.op;
                    p_next    = q_cmd.p;
                    q_next    = q_cmd.q;
                    lab_raddr = AW'(q_cmd.p);
                    priority if (q_cmd.op == umfs_pkg::OP_BAD) begin
                        ca_next    = '0;
                        sa_next    = '0;
                        bad_next   = 1'b1;
                        state_next = S_RESP;
                    end else if (q_cmd.op == umfs_pkg::OP_CLEAR) begin
                        idx_next   = IW'(1);
                        state_next = S_CLR;
                    end else begin
                        state_next = S_LA;
                    end
                end
            end
            S_LA: begin
                a_next = lab_rdata;
                if (op_reg == umfs_pkg::OP_QUERY) begin
                    cs_raddr   = lab_rdata;
                    state_next = S_QW;
                end else begin
                    lab_raddr  = AW'(q_reg);
                    state_next = S_LB;
                end
            end
            S_QW: begin
                ca_next    = cnt_rdata;
                sa_next    = sum_rdata;
                bad_next   = 1'b0;
                state_next = S_RESP;
            end
            S_LB: begin
                b_next = lab_rdata;
                if (lab_rdata == a_reg) begin
                    state_next = S_IDLE;
                end else begin
                    cs_raddr   = a_reg;
                    state_next = S_CA;
                end
            end
            S_CA: begin
                ca_next    = cnt_rdata;
                sa_next    = sum_rdata;
                cs_raddr   = b_reg;
                state_next = S_CB;
            end
            S_CB: begin
                cs_we = 1'b1;
                if (op_reg == umfs_pkg::OP_MOVE) begin
                    cs_waddr   = a_reg;
                    cnt_wdata  = ca_reg - CW'(1);
                    sum_wdata  = sa_reg - p_sum;
                    ca_next    = cnt_rdata + CW'(1);
                    sa_next    = sum_rdata + p_sum;
                    state_next = S_MV2;
                end else begin
                    // tie keeps the first operand's label
                    if (ca_reg >= cnt_rdata) begin
                        keep_next = a_reg;
                        drop_next = b_reg;
                        cs_waddr  = a_reg;
                    end else begin
                        keep_next = b_reg;
                        drop_next = a_reg;
                        cs_waddr  = b_reg;
                    end
                    cnt_wdata  = ca_reg + cnt_rdata;
                    sum_wdata  = sa_reg + sum_rdata;
                    idx_next   = IW'(1);
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_MV2: begin
                cs_we      = 1'b1;
                cs_waddr   = b_reg;
                cnt_wdata  = ca_reg;
                sum_wdata  = sa_reg;
                lab_we     = 1'b1;
                lab_waddr  = AW'(p_reg);
                lab_wdata  = b_reg;
                state_next = S_IDLE;
            end
            S_SCAN: begin
                // relabel the entry read last cycle
                if (pend_reg && (lab_rdata == drop_reg)) begin
                    lab_we    = 1'b1;
                    lab_waddr = pend_addr_reg;
                    lab_wdata = keep_reg;
                end
                if (idx_reg <= n_ext) begin
                    lab_raddr      = idx_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                    idx_next       = idx_reg + IW'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_CLR: begin
                lab_we    = 1'b1;
                lab_waddr = idx_reg[AW-1:0];
                lab_wdata = idx_reg[AW-1:0];
                cs_we     = 1'b1;
                cs_waddr  = idx_reg[AW-1:0];
                cnt_wdata = CW'(1);
                sum_wdata = SW'(idx_reg);
                idx_next  = idx_reg + IW'(1);
                if (idx_reg == n_ext) state_next = S_IDLE;
            end
            S_RESP: begin
                if (!m_valid || m_ready) begin
                    mv_next    = 1'b1;
                    ocnt_next  = ca_reg[umfs_pkg::CountW-1:0];
                    osum_next  = sa_reg;
                    ost_next   = bad_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        op_reg        <= op_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        keep_reg      <= keep_next;
        drop_reg      <= drop_next;
        ca_reg        <= ca_next;
        sa_reg        <= sa_next;
        bad_reg       <= bad_next;
        ocnt_reg      <= ocnt_next;
        osum_reg      <= osum_next;
        ost_reg       <= ost_next;
    end

    assign m_valid     = mv_reg;
    assign m_set_count = ocnt_reg;
    assign m_set_sum   = osum_reg;
    assign m_status    = ost_reg;
    assign init_busy   = (state_reg == S_INIT);

endmodule

/* sv/union_move_find_sets_top.sv */
// Disjoint-set engine over elements 1..num_elements; element i carries value i.
// Input channel s_*: action (0 union, 1 move, 2 query, 3 clear) plus two element
// indices. Result channel m_*: set_count, set_sum, status; a query or an
// out-of-range operation gives one result, union, move and clear give none.
// Config channel cfg_*: writes num_elements; write it only while the block idles.
// A classifier checks indices and pushes commands into a two-entry queue; a
// sequencer carries them out against three single-port-read RAMs (labels, counts,
// sums), one command at a time.
// Sequencer steps: query reads label, then count and sum; out-of-range just responds;
// move and union read both labels, then both counts; union then runs a relabel scan,
// one label RAM read per element; union or move on a shared set stops after the label
// reads; clear writes once per element. The label RAM read port sets the union rate.
// Reset: after aresetn the sequencer sweeps all MAX_ELEMENTS+1 entries, one per
// cycle, to make every element a singleton; the queue takes up to two items
// meanwhile, then s_ready drops until commands start to drain.
// A stalled receiver holds the result in the output register; the sequencer
// waits with the next result but keeps the queue filling.
`include "union_move_find_sets_top_defines.svh"

module union_move_find_sets_top #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_action,
    input  logic [umfs_pkg::ElemW-1:0]         s_first_element,
    input  logic [umfs_pkg::ElemW-1:0]         s_second_element,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [umfs_pkg::CountW-1:0]        m_set_count,
    output logic [umfs_pkg::SumW-1:0]          m_set_sum,
    output logic                               m_status,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [umfs_pkg::ElemW-1:0]         cfg_data
);

    localparam int AW = $clog2(MAX_ELEMENTS + 1);
    localparam int NW = (AW > umfs_pkg::ElemW) ? AW : umfs_pkg::ElemW;

    logic [umfs_pkg::ElemW-1:0] num_reg;
    logic [NW-1:0]              num_ext;
    logic [AW-1:0]              active_n;
    logic                       q_valid, q_pop, init_busy;
    umfs_pkg::umfs_cmd_t        q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= umfs_pkg::ElemW'(1024);
        end else if (cfg_valid) begin
            num_reg <= cfg_data;
        end
    end

    // clamp to the storage size
    assign num_ext  = NW'(num_reg);
    assign active_n = (num_ext > NW'(MAX_ELEMENTS)) ? AW'(MAX_ELEMENTS) : AW'(num_ext);

    umfs_front #(.AddrW(AW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .active_n(active_n),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_first_element(s_first_element), .s_second_element(s_second_element),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    umfs_back #(.MaxElements(MAX_ELEMENTS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .active_n(active_n),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_set_count(m_set_count),
        .m_set_sum(m_set_sum), .m_status(m_status), .init_busy(init_busy)
    );

    `UMFS_ASSERT_NOW(a_bad_zero, m_valid && m_status, (m_set_count == '0) && (m_set_sum == '0), "out-of-range result carries nonzero payload")
    `UMFS_ASSERT_NOW(a_init_quiet, init_busy, !m_valid && !q_pop, "sequencer active during reset sweep")
    `UMFS_ASSERT_NEXT(a_pop_nonempty, q_pop, !(s_ready == 1'b0 && $past(s_ready) == 1'b0 && $past(s_valid) == 1'b0), "queue full after pop with no push")

endmodule
